// ===== hw/rtl/stip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stip_pkg
// Shared types, constants and helpers of the string to integer parser.
// ----------------------------------------------------------------------------
package stip_pkg;

	localparam int MAX_LEN_DEF = 256;
	localparam int APB_ADDR_W  = 4;

	// Configuration register indexes (byte address is four times the index).
	localparam logic [1:0] REG_NUMBER_BASE   = 2'd0;
	localparam logic [1:0] REG_SIGNED_MODE   = 2'd1;
	localparam logic [1:0] REG_NARROW_RESULT = 2'd2;

	localparam logic [5:0] NUMBER_BASE_RST   = 6'd10;
	localparam logic       SIGNED_MODE_RST   = 1'b1;
	localparam logic       NARROW_RESULT_RST = 1'b0;

	// Character codes.
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	localparam logic [6:0] NOT_DIGIT = 7'd99;

	localparam logic [5:0] BASE_AUTO  = 6'd0;
	localparam logic [5:0] BASE_ONE   = 6'd1;
	localparam logic [5:0] BASE_TWO   = 6'd2;
	localparam logic [5:0] BASE_OCT   = 6'd8;
	localparam logic [5:0] BASE_DEC   = 6'd10;
	localparam logic [5:0] BASE_HEX   = 6'd16;
	localparam logic [5:0] BASE_MAX   = 6'd36;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_SIGNED,
		PH_ZERO,
		PH_HEX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [63:0] parsed_value;
		logic [8:0]  end_position;
		logic        saturated;
	} out_item_t;

	// Parse state as it stands after the last character of a string.
	typedef struct packed {
		logic [63:0] mag;
		logic        ovf;
		logic        neg;
		logic        any_digit;
		logic [8:0]  end_pos;
	} snap_t;

	// Value of an alphanumeric character, NOT_DIGIT for anything else.
	function automatic logic [6:0] digit_of(input logic [7:0] c);
		logic [6:0] d;
		d = NOT_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = 7'(c - CH_ZERO);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			d = 7'(c - CH_LOWER_A) + 7'd10;
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			d = 7'(c - CH_UPPER_A) + 7'd10;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/stip_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stip_scan
// Per-character parse state machine with the digit accumulate step.
// ----------------------------------------------------------------------------
module stip_scan
	import stip_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        step,
	input  in_item_t   item,
	input  wire [5:0]  number_base,
	output snap_t      snap
);

	localparam int IDX_W = $clog2(MAX_LEN + 1);
	localparam int EXT_W = (IDX_W > 9) ? IDX_W : 9;

	phase_t             phase_q, phase_d;
	logic               neg_q, neg_d;
	logic [5:0]         abase_q, abase_d;
	logic [63:0]        acc_q, acc_d;
	logic               ov_q, ov_d;
	logic               any_q, any_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [IDX_W-1:0]   lde_q, lde_d;

	logic               start, take;
	logic [5:0]         take_base;
	logic [6:0]         digit;
	logic [69:0]        prod;
	logic [70:0]        sum;
	logic [EXT_W-1:0]   end_ext;
	logic               is_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			abase_q <= '0;
			acc_q   <= '0;
			ov_q    <= 1'b0;
			any_q   <= 1'b0;
			idx_q   <= '0;
			lde_q   <= '0;
		end else begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			abase_q <= abase_d;
			acc_q   <= acc_d;
			ov_q    <= ov_d;
			any_q   <= any_d;
			idx_q   <= idx_d;
			lde_q   <= lde_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		neg_d     = neg_q;
		abase_d   = abase_q;
		acc_d     = acc_q;
		ov_d      = ov_q;
		any_d     = any_q;
		idx_d     = idx_q;
		lde_d     = lde_q;
		start     = 1'b0;
		take      = 1'b0;
		take_base = abase_q;
		digit     = digit_of(item.char_code);
		is_space  = (item.char_code == CH_SPACE) ||
			(item.char_code >= CH_TAB && item.char_code <= CH_CR);
		prod      = '0;
		sum       = '0;
		end_ext   = '0;
		snap      = '0;

		if (step) begin
			if (idx_q < IDX_W'(MAX_LEN)) begin
				idx_d = idx_q + 1'b1;
				if (item.char_code == CH_NUL) begin
					phase_d = PH_DONE;
				end else begin
					case (phase_q)
						PH_SPACE: begin
							if (is_space) begin
								phase_d = PH_SPACE;
							end else if (item.char_code == CH_MINUS ||
									item.char_code == CH_PLUS) begin
								neg_d   = (item.char_code == CH_MINUS);
								phase_d = PH_SIGNED;
							end else begin
								start = 1'b1;
							end
						end
						PH_SIGNED: begin
							start = 1'b1;
						end
						PH_ZERO: begin
							if (item.char_code == CH_LOWER_X ||
									item.char_code == CH_UPPER_X) begin
								abase_d = BASE_HEX;
								phase_d = PH_HEX;
							end else begin
								take_base = (abase_q == BASE_AUTO) ? BASE_OCT : BASE_HEX;
								abase_d   = take_base;
								take      = 1'b1;
							end
						end
						PH_HEX, PH_DIGITS: begin
							take = 1'b1;
						end
						default: begin
							phase_d = phase_q;
						end
					endcase
				end

				if (start) begin
					if (number_base == BASE_ONE || number_base > BASE_MAX) begin
						phase_d = PH_DONE;
					end else if ((number_base == BASE_AUTO || number_base == BASE_HEX) &&
							item.char_code == CH_ZERO) begin
						// A leading zero counts as a digit but may still open a hex prefix.
						any_d   = 1'b1;
						lde_d   = idx_q + 1'b1;
						acc_d   = '0;
						abase_d = number_base;
						phase_d = PH_ZERO;
					end else begin
						take_base = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
						abase_d   = take_base;
						take      = 1'b1;
					end
				end

				if (take) begin
					if (take_base < BASE_TWO || digit >= 7'(take_base)) begin
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_DIGITS;
						if (!ov_q) begin
							prod = 70'(acc_q) * 70'(take_base);
							sum  = 71'(prod) + 71'(digit);
							if (sum[70:64] != '0) begin
								ov_d  = 1'b1;
								acc_d = '1;
							end else begin
								acc_d = sum[63:0];
							end
						end
						any_d = 1'b1;
						lde_d = idx_q + 1'b1;
					end
				end
			end

			end_ext        = EXT_W'(lde_d);
			snap.mag       = acc_d;
			snap.ovf       = ov_d;
			snap.neg       = neg_d;
			snap.any_digit = any_d;
			snap.end_pos   = end_ext[8:0];

			if (item.is_last) begin
				phase_d = PH_SPACE;
				neg_d   = 1'b0;
				abase_d = '0;
				acc_d   = '0;
				ov_d    = 1'b0;
				any_d   = 1'b0;
				idx_d   = '0;
				lde_d   = '0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/stip_finish.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stip_finish
// Applies sign, range limits and saturation to a finished magnitude.
// ----------------------------------------------------------------------------
module stip_finish
	import stip_pkg::*;
(
	input  snap_t      snap,
	input  wire        signed_mode,
	input  wire        narrow_result,
	output out_item_t  result
);

	logic [63:0] lim;
	logic [63:0] neg_mag;
	logic [63:0] narrow_mag;

	always_comb begin
		lim        = narrow_result ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
		neg_mag    = 64'd0 - snap.mag;
		narrow_mag = snap.neg ? neg_mag : snap.mag;
		result     = '0;

		if (snap.any_digit) begin
			result.end_position = snap.end_pos;
			if (signed_mode) begin
				if (snap.neg) begin
					if (snap.ovf || snap.mag > lim) begin
						result.parsed_value = 64'd0 - lim;
						result.saturated    = 1'b1;
					end else begin
						result.parsed_value = neg_mag;
					end
				end else begin
					if (snap.ovf || snap.mag > lim - 64'd1) begin
						result.parsed_value = lim - 64'd1;
						result.saturated    = 1'b1;
					end else begin
						result.parsed_value = snap.mag;
					end
				end
			end else if (narrow_result) begin
				if (snap.ovf || snap.mag > 64'h0000_0000_FFFF_FFFF) begin
					result.parsed_value = 64'h0000_0000_FFFF_FFFF;
					result.saturated    = 1'b1;
				end else begin
					result.parsed_value = {32'd0, narrow_mag[31:0]};
				end
			end else begin
				if (snap.ovf) begin
					result.parsed_value = '1;
					result.saturated    = 1'b1;
				end else begin
					result.parsed_value = narrow_mag;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/string_to_integer_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// string_to_integer_parser_core
// Streaming strtol-style parser: one character per request, one result per
// string.
// ----------------------------------------------------------------------------
// The block takes one character per request and accepts a new request every
// cycle unless a last character waits for room downstream. Leading
// whitespace is skipped, an optional sign is taken, and digits are
// accumulated in the radix set by number_base (0 picks hex, octal or decimal
// from the prefix). A request marked is_last produces exactly one result
// request carrying the value, the position one past the last digit (0 when
// no digits were seen) and a saturation flag; the parser then starts over
// for the next string. The sustained rate of one character per cycle is set
// by the scan stage, where each digit takes one 64-by-6 bit multiply, an add
// and an overflow check on the carried accumulator. Pipeline stages are the
// input register, the end-of-string snapshot and the result register;
// characters that are not last keep flowing while a result waits to be
// taken. The user must write configuration through the APB port only while
// no string is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module string_to_integer_parser_core
	import stip_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,

	input  wire                   in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,

	output logic                  out_valid,
	input  wire                   out_stall,
	output out_item_t             out_data,

	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire [APB_ADDR_W-1:0]  paddr,
	input  wire [31:0]            pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	// Configuration registers.
	logic [5:0] number_base_q;
	logic       signed_mode_q;
	logic       narrow_result_q;
	logic [1:0] reg_index;
	logic       cfg_write;

	// Pipeline registers.
	logic       valid_s1;
	in_item_t   item_s1;
	logic       valid_s2;
	snap_t      snap_s2;
	logic       out_valid_q;
	out_item_t  out_data_q;

	// Handshake between stages.
	logic       out_free;
	logic       s2_free;
	logic       s1_go;
	snap_t      snap_next;
	out_item_t  result;

	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q   <= NUMBER_BASE_RST;
			signed_mode_q   <= SIGNED_MODE_RST;
			narrow_result_q <= NARROW_RESULT_RST;
		end else if (cfg_write) begin
			case (reg_index)
				REG_NUMBER_BASE:   number_base_q   <= pwdata[5:0];
				REG_SIGNED_MODE:   signed_mode_q   <= pwdata[0];
				REG_NARROW_RESULT: narrow_result_q <= pwdata[0];
				default:           number_base_q   <= number_base_q;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_NUMBER_BASE:   prdata = {26'd0, number_base_q};
			REG_SIGNED_MODE:   prdata = {31'd0, signed_mode_q};
			REG_NARROW_RESULT: prdata = {31'd0, narrow_result_q};
			default:           prdata = 32'd0;
		endcase
	end

	// A stage moves on when the stage after it is empty or empties this cycle.
	// Only a last character needs room downstream; all others retire in the
	// scan stage without producing anything.
	assign out_free = !out_valid_q || !out_stall;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_go    = valid_s1 && (!item_s1.is_last || s2_free);
	assign in_stall = valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (s1_go && item_s1.is_last) begin
				valid_s2 <= 1'b1;
			end else if (out_free) begin
				valid_s2 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (s1_go && item_s1.is_last) begin
			snap_s2 <= snap_next;
		end
		if (valid_s2 && out_free) begin
			out_data_q <= result;
		end
	end

	stip_scan #(
		.MAX_LEN (MAX_LEN)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (s1_go),
		.item        (item_s1),
		.number_base (number_base_q),
		.snap        (snap_next)
	);

	stip_finish u_finish (
		.snap          (snap_s2),
		.signed_mode   (signed_mode_q),
		.narrow_result (narrow_result_q),
		.result        (result)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	// The input side only ever waits for room behind a last character.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && item_s1.is_last))
		else $error("input stalled without a pending last character");

	// A string without digits yields an all-zero result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && MAX_LEN < 512 && out_data.end_position == 9'd0) |->
		(out_data.parsed_value == 64'd0 && !out_data.saturated))
		else $error("nonzero result with no digits consumed");

	// Narrow signed saturation lands on one of the two 32-bit limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.saturated && signed_mode_q && narrow_result_q) |->
		(out_data.parsed_value == 64'h0000_0000_7FFF_FFFF ||
		 out_data.parsed_value == 64'hFFFF_FFFF_8000_0000))
		else $error("narrow signed saturation off the 32-bit limits");

	// A snapshot is only ever taken when the stage it lands in has room.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && item_s1.is_last) |-> s2_free)
		else $error("snapshot overwrote a pending result");
`endif

endmodule
`default_nettype wire
